@@ src/prl_pkg.sv @@
package prl_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// result beat handed from the sequencer to the output register
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               banned;
		logic               was_new;
	} result_t;

endpackage

@@ src/prl_table.sv @@
module prl_table #(
	parameter int TABLE_ENTRIES = 16,
	parameter int IDX_W         = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output prl_pkg::entry_t  rd_entry_q,
	output logic             rd_valid_q,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  prl_pkg::entry_t  wr_entry
);
	import prl_pkg::*;

	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

endmodule

@@ src/prl_scan.sv @@
module prl_scan #(
	parameter int TABLE_ENTRIES = 16,
	parameter int IDX_W         = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [prl_pkg::ADDR_W-1:0]   source_addr,
	input  logic [prl_pkg::COUNT_W-1:0]  limit,
	output logic                         rd_en,
	output logic [IDX_W-1:0]             rd_idx,
	input  prl_pkg::entry_t              rd_entry,
	input  logic                         rd_valid,
	output logic                         wr_en,
	output logic [IDX_W-1:0]             wr_idx,
	output prl_pkg::entry_t              wr_entry,
	output logic                         res_valid,
	input  logic                         res_take,
	output prl_pkg::result_t             res
);
	import prl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]         state_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [IDX_W-1:0]   ptr_q;
	result_t            res_q;

	logic               hit;
	logic               last;
	logic               decide;
	logic [COUNT_W-1:0] new_count;

	// rd_entry always holds the entry at cmp_idx_q while scanning
	assign hit    = rd_valid && (rd_entry.addr == addr_q);
	assign last   = (cmp_idx_q == LAST_IDX);
	assign decide = (state_q == ST_SCAN) && (hit || last);

	always_comb begin
		if (hit) begin
			new_count = (rd_entry.count == COUNT_MAX) ? rd_entry.count
			                                          : rd_entry.count + 1'b1;
		end else begin
			new_count = COUNT_W'(1);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign rd_en     = ((state_q == ST_IDLE) && in_valid) ||
	                   ((state_q == ST_SCAN) && !hit && !last);
	assign rd_idx    = (state_q == ST_IDLE) ? '0 : cmp_idx_q + 1'b1;

	assign wr_en          = decide;
	assign wr_idx         = hit ? cmp_idx_q : ptr_q;
	assign wr_entry.addr  = addr_q;
	assign wr_entry.count = new_count;

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			addr_q <= source_addr;
		end
		if (decide) begin
			res_q.count   <= new_count;
			res_q.banned  <= (new_count > limit);
			res_q.was_new <= !hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmp_idx_q <= '0;
			ptr_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmp_idx_q <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (decide) begin
						if (!hit) begin
							ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/per_source_request_limiter.sv @@
// Per-source request limiter. Each input beat carries one IPv4 source
// address; the block walks its table one entry per cycle, using a single
// registered-read memory port and one 32-bit comparator. A source found at
// entry k returns its incremented count (saturating at 255); a new source is
// known only after the last entry is compared, and it overwrites the entry at
// a round-robin pointer with count 1. in_stall is high while the walk runs
// and until the result beat moves to the output register, so the next address
// is taken while a result waits there. banned is set when the count exceeds
// request_limit (APB, at any offset, reset value 3).
module per_source_request_limiter #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [1:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [prl_pkg::ADDR_W-1:0]  source_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [prl_pkg::COUNT_W-1:0] request_count,
	output logic                        banned,
	output logic                        was_new
);
	import prl_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [COUNT_W-1:0] limit_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_idx;
	entry_t             rd_entry;
	logic               rd_valid;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_entry;
	logic               res_valid;
	logic               res_take;
	result_t            res;

	// only one register; every offset in the window decodes to it
	logic               cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);

	assign pready = 1'b1;
	assign prdata = {{(32 - COUNT_W){1'b0}}, limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && pready) begin
			limit_q <= pwdata[COUNT_W-1:0];
		end
	end

	prl_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.rd_entry_q(rd_entry),
		.rd_valid_q(rd_valid),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_entry  (wr_entry)
	);

	prl_scan #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.source_addr(source_addr),
		.limit      (limit_q),
		.rd_en      (rd_en),
		.rd_idx     (rd_idx),
		.rd_entry   (rd_entry),
		.rd_valid   (rd_valid),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_entry   (wr_entry),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign request_count = out_q.count;
	assign banned        = out_q.banned;
	assign was_new       = out_q.was_new;

endmodule

@@ src/prl_checker.sv @@
module prl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [prl_pkg::COUNT_W-1:0] request_count,
	input logic                        banned,
	input logic                        was_new
);
	import prl_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(request_count) &&
		$stable(banned) && $stable(was_new))
		else $error("result beat changed while stalled");

	// an accepted address keeps in_stall high while the table walk runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> request_count != '0)
		else $error("zero request count on output");

	a_new_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_new |-> request_count == COUNT_W'(1))
		else $error("new source with count other than one");

endmodule

bind per_source_request_limiter prl_checker u_prl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.request_count(request_count),
	.banned       (banned),
	.was_new      (was_new)
);
